@@ src/kst_pkg.sv @@
// ----------------------------------------------------------------------------
// kst_pkg
// Shared types and codes for the kinetic scroll tracker: event codes, timer
// requests, register indexes and the one-hot tracker mode.
// ----------------------------------------------------------------------------
package kst_pkg;

  // Field widths
  localparam int unsigned CmdW   = 3;
  localparam int unsigned PosW   = 14;
  localparam int unsigned TimeW  = 16;
  localparam int unsigned DeltaW = 16;
  localparam int unsigned TimerW = 2;
  localparam int unsigned ModeW  = 3;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 10;

  typedef logic [CmdW-1:0]            cmd_t;
  typedef logic signed [PosW-1:0]     pos_t;
  typedef logic [TimeW-1:0]           stamp_t;
  typedef logic signed [DeltaW-1:0]   delta_t;
  typedef logic [TimerW-1:0]          timer_t;
  typedef logic [ModeW-1:0]           mode_code_t;
  typedef logic [CfgIdxW-1:0]         cfg_idx_t;
  typedef logic [CfgDataW-1:0]        cfg_data_t;

  // Event codes
  localparam cmd_t CMD_PRESS   = 3'd0;
  localparam cmd_t CMD_RELEASE = 3'd1;
  localparam cmd_t CMD_MOVE    = 3'd2;
  localparam cmd_t CMD_TICK    = 3'd3;
  localparam cmd_t CMD_STOP    = 3'd4;

  // Timer requests
  localparam timer_t TIMER_NONE  = 2'd0;
  localparam timer_t TIMER_START = 2'd1;
  localparam timer_t TIMER_STOP  = 2'd2;

  // Reported mode codes
  localparam mode_code_t MCODE_STEADY  = 3'd0;
  localparam mode_code_t MCODE_PRESSED = 3'd1;
  localparam mode_code_t MCODE_MANUAL  = 3'd2;
  localparam mode_code_t MCODE_AUTO    = 3'd3;
  localparam mode_code_t MCODE_STOP    = 3'd4;

  // Register indexes
  localparam cfg_idx_t REG_THRESHOLD     = 3'd0;
  localparam cfg_idx_t REG_TICK_INTERVAL = 3'd1;
  localparam cfg_idx_t REG_SAMPLE_PERIOD = 3'd2;
  localparam cfg_idx_t REG_SPEED_LIMIT   = 3'd3;
  localparam cfg_idx_t REG_DECEL_STEP    = 3'd4;

  // Register reset values
  localparam logic [7:0] THRESHOLD_RST     = 8'd10;
  localparam logic [9:0] TICK_INTERVAL_RST = 10'd20;
  localparam logic [9:0] SAMPLE_PERIOD_RST = 10'd100;
  localparam logic [9:0] SPEED_LIMIT_RST   = 10'd64;
  localparam logic [7:0] DECEL_STEP_RST    = 8'd1;

  // Tracker mode, one-hot
  typedef enum logic [4:0] {
    MODE_STEADY  = 5'b00001,
    MODE_PRESSED = 5'b00010,
    MODE_MANUAL  = 5'b00100,
    MODE_AUTO    = 5'b01000,
    MODE_STOP    = 5'b10000
  } mode_t;

endpackage

@@ src/kst_if.sv @@
// ----------------------------------------------------------------------------
// kst_if
// Valid/ready channels of the kinetic scroll tracker: the event channel and
// the result channel.
// ----------------------------------------------------------------------------

// Pointer event channel.
interface kst_in_if;
  import kst_pkg::*;

  logic   valid;
  logic   ready;
  cmd_t   cmd;
  pos_t   pos_x;
  pos_t   pos_y;
  logic   left_button;
  stamp_t now_ms;

  modport source (output valid, cmd, pos_x, pos_y, left_button, now_ms, input ready);
  modport sink   (input valid, cmd, pos_x, pos_y, left_button, now_ms, output ready);
endinterface

// Scroll result channel.
interface kst_out_if;
  import kst_pkg::*;

  logic       valid;
  logic       ready;
  logic       delta_valid;
  delta_t     delta_x;
  delta_t     delta_y;
  timer_t     timer_action;
  logic       scrolling;
  mode_code_t mode_out;

  modport source (output valid, delta_valid, delta_x, delta_y, timer_action, scrolling,
                  mode_out, input ready);
  modport sink   (input valid, delta_valid, delta_x, delta_y, timer_action, scrolling,
                  mode_out, output ready);
endinterface

@@ src/kinetic_scroll_tracker_unit.sv @@
// ----------------------------------------------------------------------------
// kinetic_scroll_tracker_unit
// Kinetic (flick) scrolling tracker: turns pointer events into scroll deltas,
// autoscroll speeds and timer requests.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one pointer event per transfer (press, release, move,
//   autoscroll tick or forced stop) with position, left-button flag and a
//   millisecond timestamp. out_ch returns exactly one result per event: the
//   delta, a timer start/stop request, the scrolling flag and the new mode.
//   The cfg_* port writes the five tuning registers; write them only while
//   no event is in flight.
// Timing:
//   An event is captured in an input register, processed by combinational
//   logic and lands in the result register once that register is free. One
//   event is taken every cycle while out_ch.ready is high; the tracker state
//   is updated in the same cycle the result is loaded, so back-to-back
//   events see each other's effect.
// Reset:
//   rst_n (synchronous, active low) empties both registers, puts the tracker
//   in steady mode with zero anchor, speed and sample stamp, and loads the
//   register defaults.
// Stall:
//   While out_ch.ready is low the result holds; one more event is taken into
//   the input register, after which in_ch.ready drops until the result moves.
// ----------------------------------------------------------------------------
module kinetic_scroll_tracker_unit (
  input  logic               clk,
  input  logic               rst_n,
  kst_in_if.sink             in_ch,
  kst_out_if.source          out_ch,
  input  logic               cfg_we,
  input  kst_pkg::cfg_idx_t  cfg_idx,
  input  kst_pkg::cfg_data_t cfg_wdata
);
  import kst_pkg::*;

  // Configuration registers
  logic [7:0] threshold_r;
  logic [9:0] tick_interval_r;
  logic [9:0] sample_period_r;
  logic [9:0] speed_limit_r;
  logic [7:0] decel_step_r;

  // Input stage
  logic   in_vld_r;
  cmd_t   cmd_r;
  pos_t   pos_x_r, pos_y_r;
  logic   left_r;
  stamp_t now_r;

  // Tracker state
  mode_t               mode_r, mode_nxt;
  pos_t                anchor_x_r, anchor_x_nxt, anchor_y_r, anchor_y_nxt;
  logic signed [14:0]  sampled_dx_r, sampled_dx_nxt, sampled_dy_r, sampled_dy_nxt;
  delta_t              speed_x_r, speed_x_nxt, speed_y_r, speed_y_nxt;
  stamp_t              stamp_r, stamp_nxt;

  // Result stage
  logic       out_vld_r;
  logic       dv_r, dv_nxt;
  delta_t     ox_r, ox_nxt, oy_r, oy_nxt;
  timer_t     timer_r, timer_nxt;
  logic       scroll_r;
  mode_code_t mcode_r, mcode_nxt;

  // Datapath intermediates
  logic               advance;
  logic               fire;
  logic signed [14:0] dx, dy;
  logic signed [15:0] dx_w, dy_w, th_w;
  logic               over_th;
  stamp_t             elapsed;
  logic               do_sample;
  delta_t             rs_speed_x, rs_speed_y;
  delta_t             rel_speed_x, rel_speed_y;
  delta_t             tick_x, tick_y;

  // Clamp to +-lim, then step the magnitude toward zero by dec.
  function automatic delta_t slow_down(input delta_t v, input logic [9:0] lim,
                                       input logic [7:0] dec);
    logic signed [16:0] v_w, lim_w, c, t, r;
    v_w   = 17'(v);
    lim_w = $signed({7'd0, lim});
    if (v_w > lim_w) begin
      c = lim_w;
    end else if (v_w < -lim_w) begin
      c = -lim_w;
    end else begin
      c = v_w;
    end
    if (c > 17'sd0) begin
      t = c - $signed({9'd0, dec});
      r = (t > 17'sd0) ? t : 17'sd0;
    end else if (c < 17'sd0) begin
      t = c + $signed({9'd0, dec});
      r = (t < 17'sd0) ? t : 17'sd0;
    end else begin
      r = 17'sd0;
    end
    return r[15:0];
  endfunction

  // Map the one-hot mode to its reported code.
  function automatic mode_code_t mode_code(input mode_t m);
    mode_code_t code;
    unique case (m)
      MODE_STEADY:  code = MCODE_STEADY;
      MODE_PRESSED: code = MCODE_PRESSED;
      MODE_MANUAL:  code = MCODE_MANUAL;
      MODE_AUTO:    code = MCODE_AUTO;
      MODE_STOP:    code = MCODE_STOP;
      default:      code = MCODE_STEADY;
    endcase
    return code;
  endfunction

  // Handshake: the input register moves on when the result register is free.
  assign advance     = !out_vld_r || out_ch.ready;
  assign fire        = in_vld_r && advance;
  assign in_ch.ready = !in_vld_r || advance;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r     <= THRESHOLD_RST;
      tick_interval_r <= TICK_INTERVAL_RST;
      sample_period_r <= SAMPLE_PERIOD_RST;
      speed_limit_r   <= SPEED_LIMIT_RST;
      decel_step_r    <= DECEL_STEP_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_THRESHOLD:     threshold_r     <= cfg_wdata[7:0];
        REG_TICK_INTERVAL: tick_interval_r <= cfg_wdata;
        REG_SAMPLE_PERIOD: sample_period_r <= cfg_wdata;
        REG_SPEED_LIMIT:   speed_limit_r   <= cfg_wdata;
        REG_DECEL_STEP:    decel_step_r    <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      cmd_r   <= in_ch.cmd;
      pos_x_r <= in_ch.pos_x;
      pos_y_r <= in_ch.pos_y;
      left_r  <= in_ch.left_button;
      now_r   <= in_ch.now_ms;
    end
  end

  // Offsets from the anchor and the drag threshold test.
  assign dx      = 15'(pos_x_r) - 15'(anchor_x_r);
  assign dy      = 15'(pos_y_r) - 15'(anchor_y_r);
  assign dx_w    = 16'(dx);
  assign dy_w    = 16'(dy);
  assign th_w    = $signed({8'd0, threshold_r});
  assign over_th = (dx_w > th_w) || (dx_w < -th_w) || (dy_w > th_w) || (dy_w < -th_w);

  // Speed resampling: elapsed time wraps at 16 bits.
  assign elapsed     = now_r - stamp_r;
  assign do_sample   = elapsed > {6'd0, sample_period_r};
  assign rs_speed_x  = 16'(dx) - 16'(sampled_dx_r);
  assign rs_speed_y  = 16'(dy) - 16'(sampled_dy_r);
  assign rel_speed_x = do_sample ? rs_speed_x : speed_x_r;
  assign rel_speed_y = do_sample ? rs_speed_y : speed_y_r;

  // Autoscroll tick speeds.
  assign tick_x = slow_down(speed_x_r, speed_limit_r, decel_step_r);
  assign tick_y = slow_down(speed_y_r, speed_limit_r, decel_step_r);

  // Event processing: next tracker state and the result.
  always_comb begin
    mode_nxt       = mode_r;
    anchor_x_nxt   = anchor_x_r;
    anchor_y_nxt   = anchor_y_r;
    sampled_dx_nxt = sampled_dx_r;
    sampled_dy_nxt = sampled_dy_r;
    speed_x_nxt    = speed_x_r;
    speed_y_nxt    = speed_y_r;
    stamp_nxt      = stamp_r;
    dv_nxt         = 1'b0;
    ox_nxt         = '0;
    oy_nxt         = '0;
    timer_nxt      = TIMER_NONE;

    unique case (cmd_r)
      CMD_PRESS: begin
        if (left_r) begin
          if (mode_r == MODE_STEADY) begin
            mode_nxt     = MODE_PRESSED;
            anchor_x_nxt = pos_x_r;
            anchor_y_nxt = pos_y_r;
          end else if (mode_r == MODE_AUTO) begin
            // A press during autoscroll catches the content.
            mode_nxt     = MODE_STOP;
            speed_x_nxt  = '0;
            speed_y_nxt  = '0;
            anchor_x_nxt = pos_x_r;
            anchor_y_nxt = pos_y_r;
            timer_nxt    = TIMER_STOP;
          end
        end
      end
      CMD_RELEASE: begin
        if (left_r) begin
          if (mode_r == MODE_PRESSED || mode_r == MODE_STOP) begin
            mode_nxt = MODE_STEADY;
          end else if (mode_r == MODE_MANUAL) begin
            dv_nxt       = 1'b1;
            ox_nxt       = 16'(dx);
            oy_nxt       = 16'(dy);
            anchor_x_nxt = pos_x_r;
            anchor_y_nxt = pos_y_r;
            if (do_sample) begin
              stamp_nxt      = now_r;
              sampled_dx_nxt = dx;
              sampled_dy_nxt = dy;
            end
            speed_x_nxt = rel_speed_x;
            speed_y_nxt = rel_speed_y;
            // A flick with any speed left starts autoscroll.
            if (rel_speed_x == '0 && rel_speed_y == '0) begin
              mode_nxt = MODE_STEADY;
            end else begin
              mode_nxt  = MODE_AUTO;
              timer_nxt = TIMER_START;
            end
          end
        end
      end
      CMD_MOVE: begin
        if (left_r) begin
          if (mode_r == MODE_PRESSED || mode_r == MODE_STOP) begin
            if (over_th) begin
              stamp_nxt      = now_r;
              mode_nxt       = MODE_MANUAL;
              sampled_dx_nxt = '0;
              sampled_dy_nxt = '0;
              anchor_x_nxt   = pos_x_r;
              anchor_y_nxt   = pos_y_r;
              dv_nxt         = 1'b1;
              ox_nxt         = 16'(dx);
              oy_nxt         = 16'(dy);
            end
          end else if (mode_r == MODE_MANUAL) begin
            dv_nxt       = 1'b1;
            ox_nxt       = 16'(dx);
            oy_nxt       = 16'(dy);
            anchor_x_nxt = pos_x_r;
            anchor_y_nxt = pos_y_r;
            if (do_sample) begin
              stamp_nxt      = now_r;
              speed_x_nxt    = rs_speed_x;
              speed_y_nxt    = rs_speed_y;
              sampled_dx_nxt = dx;
              sampled_dy_nxt = dy;
            end
          end
        end
      end
      CMD_TICK: begin
        if (mode_r == MODE_AUTO) begin
          speed_x_nxt = tick_x;
          speed_y_nxt = tick_y;
          dv_nxt      = 1'b1;
          ox_nxt      = tick_x;
          oy_nxt      = tick_y;
          if (tick_x == '0 && tick_y == '0) begin
            mode_nxt  = MODE_STEADY;
            timer_nxt = TIMER_STOP;
          end
        end else begin
          timer_nxt = TIMER_STOP;
        end
      end
      CMD_STOP: begin
        mode_nxt    = MODE_STEADY;
        speed_x_nxt = '0;
        speed_y_nxt = '0;
        timer_nxt   = TIMER_STOP;
      end
      default: ;
    endcase

    mcode_nxt = mode_code(mode_nxt);
  end

  // Tracker state update, once per processed event.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_STEADY;
      anchor_x_r   <= '0;
      anchor_y_r   <= '0;
      sampled_dx_r <= '0;
      sampled_dy_r <= '0;
      speed_x_r    <= '0;
      speed_y_r    <= '0;
      stamp_r      <= '0;
    end else if (fire) begin
      mode_r       <= mode_nxt;
      anchor_x_r   <= anchor_x_nxt;
      anchor_y_r   <= anchor_y_nxt;
      sampled_dx_r <= sampled_dx_nxt;
      sampled_dy_r <= sampled_dy_nxt;
      speed_x_r    <= speed_x_nxt;
      speed_y_r    <= speed_y_nxt;
      stamp_r      <= stamp_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      dv_r     <= dv_nxt;
      ox_r     <= ox_nxt;
      oy_r     <= oy_nxt;
      timer_r  <= timer_nxt;
      scroll_r <= (mode_nxt == MODE_MANUAL) || (mode_nxt == MODE_AUTO);
      mcode_r  <= mcode_nxt;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.delta_valid  = dv_r;
  assign out_ch.delta_x      = ox_r;
  assign out_ch.delta_y      = oy_r;
  assign out_ch.timer_action = timer_r;
  assign out_ch.scrolling    = scroll_r;
  assign out_ch.mode_out     = mcode_r;

  // The tick period is taken by the external timer on a start request; it is
  // held here so the setting travels with the tracker configuration.
  logic tick_interval_unused;
  assign tick_interval_unused = ^tick_interval_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // A processed event always lands in the result register.
  a_fire_lands: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_vld_r)
    else $error("processed event did not reach the result register");

  // The scrolling flag agrees with the reported mode.
  a_scroll_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (scroll_r == ((mcode_r == MCODE_MANUAL) || (mcode_r == MCODE_AUTO))))
    else $error("scrolling flag disagrees with mode");

  // No delta is reported as nonzero without delta_valid.
  a_delta_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !dv_r) |-> (ox_r == '0 && oy_r == '0))
    else $error("nonzero delta without delta_valid");

  // A timer start only comes with entry into autoscroll on a release delta.
  a_start_auto: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && timer_r == TIMER_START) |-> (mcode_r == MCODE_AUTO && dv_r))
    else $error("timer start without autoscroll");

  // Autoscroll always holds a nonzero speed.
  a_auto_speed: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_AUTO) |-> (speed_x_r != '0 || speed_y_r != '0))
    else $error("autoscroll with zero speed");

endmodule
